FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled in reset.
`define ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

FILE: src/lfuc_pkg.sv
// Package for the LFU cache: defaults and operation codes.
package lfuc_pkg;
   localparam int CAPACITY_DEF   = 16;
   localparam int COUNT_BITS_DEF = 16;
   localparam int EFF_BITS       = 9;
   localparam logic [4:0] CAPACITY_RESET = 5'd16;
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;
endpackage

FILE: src/lfuc_cell.sv
// One cache entry cell: scans the passing request and applies updates.
module lfuc_cell #(
   parameter int IDX = 0,
   parameter int IW  = 4,
   parameter int CW  = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic [32+32+1+IW+IW+1+CW+IW+IW+32+1+IW-1:0] tok_in,
   input  logic [1+1+IW+IW+1+1+IW+32+32-1:0]           upd_in,
   output logic [32+32+1+IW+IW+1+CW+IW+IW+32+1+IW-1:0] tok_out
);
   import lfuc_pkg::*;

   typedef struct packed {
      logic [31:0]   key;
      logic [31:0]   data;
      logic          found;
      logic [IW-1:0] fidx;
      logic [IW-1:0] frank;
      logic          have;
      logic [CW-1:0] vcount;
      logic [IW-1:0] vrank;
      logic [IW-1:0] vidx;
      logic [31:0]   vkey;
      logic          free_found;
      logic [IW-1:0] free_idx;
   } scan_type;

   typedef struct packed {
      logic          en;
      logic          ins;
      logic [IW-1:0] slot;
      logic [IW-1:0] rank;
      logic          put;
      logic          evict;
      logic [IW-1:0] vidx;
      logic [31:0]   key;
      logic [31:0]   data;
   } upd_type;

   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   scan_type tin, tok_in_s, tok_ff;
   upd_type  upd;
   logic          valid_ff;
   logic [31:0]   key_ff, data_ff;
   logic [CW-1:0] count_ff;
   logic [IW-1:0] rank_ff;
   logic          match, better;

   assign tin = scan_type'(tok_in);
   assign upd = upd_type'(upd_in);
   assign tok_out = tok_ff;

   assign match  = valid_ff && !tin.found && (key_ff == tin.key);
   assign better = valid_ff && (!tin.have || count_ff < tin.vcount ||
                   (count_ff == tin.vcount && rank_ff > tin.vrank));

   always_comb begin
      tok_in_s = tin;
      if (match) begin
         tok_in_s.found = 1'b1;
         tok_in_s.fidx  = MY_IDX;
         tok_in_s.frank = rank_ff;
         tok_in_s.data  = data_ff;
      end
      if (better) begin
         tok_in_s.have   = 1'b1;
         tok_in_s.vcount = count_ff;
         tok_in_s.vrank  = rank_ff;
         tok_in_s.vidx   = MY_IDX;
         tok_in_s.vkey   = key_ff;
      end
      if (!valid_ff && !tin.free_found) begin
         tok_in_s.free_found = 1'b1;
         tok_in_s.free_idx   = MY_IDX;
      end
   end

   always_ff @(posedge clock) tok_ff <= tok_in_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
         rank_ff  <= '0;
      end else if (upd.en) begin
         if (!upd.ins) begin
            // touch: hit entry becomes newest, younger ones age
            if (upd.slot == MY_IDX) begin
               rank_ff <= '0;
               if (count_ff != '1) count_ff <= count_ff + 1'b1;
               if (upd.put) data_ff <= upd.data;
            end else if (valid_ff && rank_ff < upd.rank) begin
               rank_ff <= rank_ff + 1'b1;
            end
         end else if (upd.slot == MY_IDX) begin
            valid_ff <= 1'b1;
            key_ff   <= upd.key;
            data_ff  <= upd.data;
            count_ff <= '0;
            rank_ff  <= '0;
         end else if (upd.evict && upd.vidx == MY_IDX) begin
            valid_ff <= 1'b0;
         end else if (valid_ff) begin
            // net of victim removal and insertion aging
            if (!upd.evict || rank_ff < upd.rank) rank_ff <= rank_ff + 1'b1;
         end
      end
   end
endmodule

FILE: src/lfu_cache_lru_tiebreak.sv
// Top level of the LFU cache with LRU tie-break, built as a chain of entry cells.
// Usage:
//  - req channel (req_valid/req_stall): op (get/put), key, value. One request
//    is taken at a time; req_stall is high while a request is in flight.
//  - rsp channel (rsp_valid/rsp_stall): hit, read_value, evicted, evicted_key,
//    one response per request, held stable while rsp_stall is high.
//  - csr channel (csr_valid/csr_ready): capacity write; it takes effect only
//    while the cache is empty, otherwise it is dropped. csr_ready is always high.
// Sequencing:
//  - A request walks the cell chain one cell per cycle during the scan state;
//    the apply state then applies the update to all cells and loads the
//    response register. The next request is taken only after the previous
//    one has left the apply state and req_stall has dropped.
//  - If the previous response is still stalled, the apply cycle waits.
// Reset (synchronous): all entries invalid, counts and ranks zero, occupancy
// zero, capacity 16, no response pending.
module lfu_cache_lru_tiebreak #(
   parameter int CAPACITY   = lfuc_pkg::CAPACITY_DEF,
   parameter int COUNT_BITS = lfuc_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [31:0] rsp_read_value,
   output logic        rsp_evicted,
   output logic [31:0] rsp_evicted_key,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);
   import lfuc_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OW = $clog2(CAPACITY + 1);
   localparam int CW = COUNT_BITS;
   localparam int TW = 32+32+1+IW+IW+1+CW+IW+IW+32+1+IW;
   localparam int UW = 1+1+IW+IW+1+1+IW+32+32;

   // frank carries the hit entry's rank so the touch can age younger entries.
   typedef struct packed {
      logic [31:0]   key;
      logic [31:0]   data;
      logic          found;
      logic [IW-1:0] fidx;
      logic [IW-1:0] frank;
      logic          have;
      logic [CW-1:0] vcount;
      logic [IW-1:0] vrank;
      logic [IW-1:0] vidx;
      logic [31:0]   vkey;
      logic          free_found;
      logic [IW-1:0] free_idx;
   } scan_type;

   typedef struct packed {
      logic          en;
      logic          ins;
      logic [IW-1:0] slot;
      logic [IW-1:0] rank;
      logic          put;
      logic          evict;
      logic [IW-1:0] vidx;
      logic [31:0]   key;
      logic [31:0]   data;
   } upd_type;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_APPLY} state_type;

   state_type      state_ff;
   logic [IW-1:0]  cnt_ff;
   logic           op_ff;
   logic [31:0]    key_ff, value_ff;
   logic [4:0]     capacity_ff;
   logic [OW-1:0]  occ_ff;
   logic           rsp_valid_ff, hit_ff, evicted_ff;
   logic [31:0]    read_value_ff, evicted_key_ff;

   logic [TW-1:0]  chain [CAPACITY+1];
   scan_type       head, tail;
   upd_type        upd;
   logic [EFF_BITS-1:0] eff;
   logic           go, do_ins, do_ev, have_slot;
   logic [IW-1:0]  ins_idx;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = evicted_key_ff;

   // Scan token entering the first cell: nothing found yet.
   always_comb begin
      head = '0;
      head.key = key_ff;
   end
   assign chain[0] = head;
   assign tail = scan_type'(chain[CAPACITY]);

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      lfuc_cell #(.IDX(g), .IW(IW), .CW(CW)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_in (chain[g]),
         .upd_in (UW'(upd)),
         .tok_out(chain[g+1])
      );
   end

   // Effective capacity is clipped to the number of cells.
   assign eff = (EFF_BITS'(capacity_ff) > EFF_BITS'(CAPACITY)) ?
                EFF_BITS'(CAPACITY) : EFF_BITS'(capacity_ff);
   assign go  = (state_ff == ST_APPLY) && (!rsp_valid_ff || !rsp_stall);

   assign do_ins    = !tail.found && (op_ff == OP_PUT) && (eff != '0);
   assign do_ev     = do_ins && (EFF_BITS'(occ_ff) >= eff) && tail.have;
   assign have_slot = tail.free_found || do_ev;
   // First free slot after a possible eviction.
   assign ins_idx   = (do_ev && !(tail.free_found && tail.free_idx < tail.vidx)) ?
                      tail.vidx : tail.free_idx;

   always_comb begin
      upd       = '0;
      upd.en    = go && (tail.found || (do_ins && have_slot));
      upd.ins   = !tail.found;
      upd.slot  = tail.found ? tail.fidx : ins_idx;
      upd.rank  = tail.found ? tail.frank : tail.vrank;
      upd.put   = (op_ff == OP_PUT);
      upd.evict = do_ev;
      upd.vidx  = tail.vidx;
      upd.key   = key_ff;
      upd.data  = value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         capacity_ff  <= CAPACITY_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready && occ_ff == '0) capacity_ff <= csr_data;
         // a new response may replace one taken at the same edge
         if (go) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_op;
                  key_ff   <= req_key;
                  value_ff <= req_value;
                  cnt_ff   <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == IW'(CAPACITY - 1)) state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               if (go) begin
                  hit_ff         <= tail.found;
                  read_value_ff  <= (tail.found && op_ff == OP_GET) ? tail.data : '0;
                  evicted_ff     <= do_ev;
                  evicted_key_ff <= do_ev ? tail.vkey : '0;
                  if (do_ins && have_slot && !do_ev) occ_ff <= occ_ff + 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

FILE: src/lfuc_checker.sv
// Port-level checker for the LFU cache, bound to the top level.
`include "assert_macros.svh"
module lfuc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_hit,
   input logic [31:0] rsp_read_value,
   input logic        rsp_evicted,
   input logic [31:0] rsp_evicted_key
);
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
                $stable(rsp_read_value) && $stable(rsp_evicted_key))
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_IMP(a_ev_miss, clock, reset, rsp_valid && rsp_evicted, !rsp_hit)
   `ASSERT_IMP(a_ev_key, clock, reset, rsp_valid && !rsp_evicted, rsp_evicted_key == '0)
   `ASSERT_IMP(a_miss_rd, clock, reset, rsp_valid && !rsp_hit, rsp_read_value == '0)
endmodule

bind lfu_cache_lru_tiebreak lfuc_checker u_lfuc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hit        (rsp_hit),
   .rsp_read_value (rsp_read_value),
   .rsp_evicted    (rsp_evicted),
   .rsp_evicted_key(rsp_evicted_key)
);
